// ===== rtl/tfn_pkg.sv =====
`timescale 1ns / 1ps
package tfn_pkg;
   localparam int COORD_BITS_DEF     = 20;
   localparam int NORM_FRAC_BITS_DEF = 14;
   localparam int NUM_VERTEX_FIELDS  = 9;
   localparam int NUM_NORM_FIELDS    = 3;
endpackage

// ===== rtl/tfn_cross.sv =====
`timescale 1ns / 1ps
module tfn_cross import tfn_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int DW = COORD_BITS + 1,
   localparam int NW = 2 * DW + 1
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              up_valid,
   output logic                                              up_ready,
   input  logic [NUM_VERTEX_FIELDS-1:0][COORD_BITS-1:0]      up_coord,
   output logic                                              dn_valid,
   input  logic                                              dn_ready,
   output logic [2:0][NW-1:0]                                dn_cross
);
   logic [2:0] vld_ff;
   logic [2:0] en;
   logic signed [DW-1:0]   u_in [3];
   logic signed [DW-1:0]   v_in [3];
   logic signed [DW-1:0]   u_ff [3];
   logic signed [DW-1:0]   v_ff [3];
   logic signed [2*DW-1:0] pa_in [3];
   logic signed [2*DW-1:0] pb_in [3];
   logic signed [2*DW-1:0] pa_ff [3];
   logic signed [2*DW-1:0] pb_ff [3];
   logic signed [NW-1:0]   n_in [3];
   logic [2:0][NW-1:0]     n_ff;

   always_comb begin
      en[2] = !vld_ff[2] || dn_ready;
      en[1] = !vld_ff[1] || en[2];
      en[0] = !vld_ff[0] || en[1];
   end

   // edges B-A and C-A
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         u_in[j] = $signed({up_coord[3+j][COORD_BITS-1], up_coord[3+j]})
                 - $signed({up_coord[j][COORD_BITS-1], up_coord[j]});
         v_in[j] = $signed({up_coord[6+j][COORD_BITS-1], up_coord[6+j]})
                 - $signed({up_coord[j][COORD_BITS-1], up_coord[j]});
      end
   end

   always_comb begin
      pa_in[0] = u_ff[1] * v_ff[2];
      pb_in[0] = u_ff[2] * v_ff[1];
      pa_in[1] = u_ff[2] * v_ff[0];
      pb_in[1] = u_ff[0] * v_ff[2];
      pa_in[2] = u_ff[0] * v_ff[1];
      pb_in[2] = u_ff[1] * v_ff[0];
      for (int j = 0; j < 3; j++) begin
         n_in[j] = NW'(pa_ff[j]) - NW'(pb_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= up_valid;
         if (en[1]) vld_ff[1] <= vld_ff[0];
         if (en[2]) vld_ff[2] <= vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         if (en[0]) begin
            u_ff[j] <= u_in[j];
            v_ff[j] <= v_in[j];
         end
         if (en[1]) begin
            pa_ff[j] <= pa_in[j];
            pb_ff[j] <= pb_in[j];
         end
         if (en[2]) n_ff[j] <= n_in[j];
      end
   end

   assign up_ready = en[0];
   assign dn_valid = vld_ff[2];
   assign dn_cross = n_ff;
endmodule

// ===== rtl/tfn_square.sv =====
`timescale 1ns / 1ps
module tfn_square import tfn_pkg::*; #(
   parameter int NW   = 43,
   parameter int SQW  = 88,
   parameter int DWID = 122,
   parameter int FRAC = NORM_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  logic [2:0][NW-1:0]    up_cross,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output logic [2:0][DWID-1:0]  dn_d,
   output logic [2:0][DWID-1:0]  dn_p,
   output logic [2:0]            dn_neg,
   output logic                  dn_zero,
   output logic [SQW-1:0]        dn_sq
);
   localparam int L = (NW + 1) / 2;
   localparam int H = NW - L;

   logic [4:0] vld_ff;
   logic [4:0] en;
   logic [2:0][NW-1:0]     mag_ff;
   logic [2:0]             neg0_ff, neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic                   zero0_ff, zero1_ff, zero2_ff, zero3_ff, zero4_ff;
   logic [2:0][2*H-1:0]    hh_ff;
   logic [2:0][NW-1:0]     hl_ff;
   logic [2:0][2*L-1:0]    ll_ff;
   logic [2:0][2*NW-1:0]   sqr_in, sqr2_ff, sqr3_ff;
   logic [SQW-1:0]         sq_in, sq3_ff, sq4_ff;
   logic [2:0][DWID-1:0]   d_in, p_in, d_ff, p_ff;

   always_comb begin
      en[4] = !vld_ff[4] || dn_ready;
      for (int k = 3; k >= 0; k--) en[k] = !vld_ff[k] || en[k+1];
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sqr_in[j] = ((2*NW)'(hh_ff[j]) << (2*L)) + ((2*NW)'(hl_ff[j]) << (L+1))
                   + (2*NW)'(ll_ff[j]);
      end
      sq_in = SQW'(sqr2_ff[0]) + SQW'(sqr2_ff[1]) + SQW'(sqr2_ff[2]);
      for (int j = 0; j < 3; j++) begin
         // seed the search with k = -1: D = t^2 - sq, P = -sq
         d_in[j] = (DWID'(sqr3_ff[j]) << (2*FRAC+2)) - DWID'(sq3_ff);
         p_in[j] = DWID'(0) - DWID'(sq3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= up_valid;
         for (int k = 1; k < 5; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int j = 0; j < 3; j++) begin
            neg0_ff[j] <= up_cross[j][NW-1];
            mag_ff[j]  <= up_cross[j][NW-1] ? NW'(0) - up_cross[j] : up_cross[j];
         end
         zero0_ff <= (up_cross == '0);
      end
      if (en[1]) begin
         for (int j = 0; j < 3; j++) begin
            hh_ff[j] <= (2*H)'(mag_ff[j][NW-1:L]) * (2*H)'(mag_ff[j][NW-1:L]);
            hl_ff[j] <= NW'(mag_ff[j][NW-1:L]) * NW'(mag_ff[j][L-1:0]);
            ll_ff[j] <= (2*L)'(mag_ff[j][L-1:0]) * (2*L)'(mag_ff[j][L-1:0]);
         end
         neg1_ff  <= neg0_ff;
         zero1_ff <= zero0_ff;
      end
      if (en[2]) begin
         sqr2_ff  <= sqr_in;
         neg2_ff  <= neg1_ff;
         zero2_ff <= zero1_ff;
      end
      if (en[3]) begin
         sqr3_ff  <= sqr2_ff;
         sq3_ff   <= sq_in;
         neg3_ff  <= neg2_ff;
         zero3_ff <= zero2_ff;
      end
      if (en[4]) begin
         d_ff     <= d_in;
         p_ff     <= p_in;
         sq4_ff   <= sq3_ff;
         neg4_ff  <= neg3_ff;
         zero4_ff <= zero3_ff;
      end
   end

   assign up_ready = en[0];
   assign dn_valid = vld_ff[4];
   assign dn_d     = d_ff;
   assign dn_p     = p_ff;
   assign dn_neg   = neg4_ff;
   assign dn_zero  = zero4_ff;
   assign dn_sq    = sq4_ff;
endmodule

// ===== rtl/tfn_step.sv =====
`timescale 1ns / 1ps
module tfn_step import tfn_pkg::*; #(
   parameter int SQW  = 88,
   parameter int DWID = 122,
   parameter int FRAC = NORM_FRAC_BITS_DEF,
   parameter int BIT  = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  logic [2:0][DWID-1:0]  up_d,
   input  logic [2:0][DWID-1:0]  up_p,
   input  logic [2:0][FRAC:0]    up_n,
   input  logic [2:0]            up_neg,
   input  logic                  up_zero,
   input  logic [SQW-1:0]        up_sq,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output logic [2:0][DWID-1:0]  dn_d,
   output logic [2:0][DWID-1:0]  dn_p,
   output logic [2:0][FRAC:0]    dn_n,
   output logic [2:0]            dn_neg,
   output logic                  dn_zero,
   output logic [SQW-1:0]        dn_sq
);
   logic                  vld_ff, en;
   logic [DWID-1:0]       sq_ext;
   logic [DWID-1:0]       trial [3];
   logic [2:0]            take;
   logic [2:0][DWID-1:0]  d_in, p_in, d_ff, p_ff;
   logic [2:0][FRAC:0]    n_in, n_ff;
   logic [2:0]            neg_ff;
   logic                  zero_ff;
   logic [SQW-1:0]        sq_ff;

   assign en = !vld_ff || dn_ready;
   assign sq_ext = DWID'(up_sq);

   // trial k' = k + 2^(BIT+1): D' = D - 2^(BIT+2)*P - 4^(BIT+1)*sq
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         trial[j] = up_d[j] - (up_p[j] << (BIT+2)) - (sq_ext << (2*BIT+2));
         // hold once the value has reached one
         take[j]  = !trial[j][DWID-1] && !up_n[j][FRAC];
         d_in[j]  = take[j] ? trial[j] : up_d[j];
         p_in[j]  = take[j] ? up_p[j] + (sq_ext << (BIT+1)) : up_p[j];
         n_in[j]  = take[j] ? (up_n[j] | ((FRAC+1)'(1) << BIT)) : up_n[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in;
         p_ff    <= p_in;
         n_ff    <= n_in;
         neg_ff  <= up_neg;
         zero_ff <= up_zero;
         sq_ff   <= up_sq;
      end
   end

   assign up_ready = en;
   assign dn_valid = vld_ff;
   assign dn_d     = d_ff;
   assign dn_p     = p_ff;
   assign dn_n     = n_ff;
   assign dn_neg   = neg_ff;
   assign dn_zero  = zero_ff;
   assign dn_sq    = sq_ff;
endmodule

// ===== rtl/triangle_face_normal.sv =====
`timescale 1ns / 1ps
// channel  | dir | tdata fields, lowest bits first
// req_     | in  | a_x a_y a_z b_x b_y b_z c_x c_y c_z (COORD_BITS each), zero pad
// rsp_     | out | norm_x norm_y norm_z (NORMAL_FRAC_BITS+2 each), zero pad
//
// One triangle per cycle sustained while rsp_tready holds high; a triangle passes the
// edge and cross-product registers, the squares-and-sum registers, a step stage for
// each result bit in the rounding search, and then one output register.
// Reset clears only the valid bits. Every stage has its own ready, so a stall
// fills bubbles and drops or repeats no word.
module triangle_face_normal import tfn_pkg::*; #(
   parameter int COORD_BITS       = COORD_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = NORM_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
   input  logic [((NUM_VERTEX_FIELDS*COORD_BITS+7)/8)*8-1:0]        req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // norm_x, norm_y, norm_z
   output logic [((NUM_NORM_FIELDS*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] rsp_tdata
);
   localparam int F     = NORMAL_FRAC_BITS;
   localparam int DW    = COORD_BITS + 1;
   localparam int NW    = 2 * DW + 1;
   localparam int SQW   = 2 * NW + 2;
   localparam int DWID  = 2 * NW + 2 * F + 8;
   localparam int OW    = F + 2;
   localparam int OUT_W = ((NUM_NORM_FIELDS*OW+7)/8)*8;

   logic [NUM_VERTEX_FIELDS-1:0][COORD_BITS-1:0] coord;
   logic                 cr_valid, cr_ready;
   logic [2:0][NW-1:0]   cr_n;

   logic [F+1:0]          st_valid, st_ready;
   logic [2:0][DWID-1:0]  st_d   [F+2];
   logic [2:0][DWID-1:0]  st_p   [F+2];
   logic [2:0][F:0]       st_n   [F+2];
   logic [2:0]            st_neg [F+2];
   logic                  st_zero [F+2];
   logic [SQW-1:0]        st_sq  [F+2];

   logic                  out_vld_ff;
   logic [2:0][OW-1:0]    norm_in, norm_ff;

   always_comb begin
      for (int k = 0; k < NUM_VERTEX_FIELDS; k++) begin
         coord[k] = req_tdata[k*COORD_BITS +: COORD_BITS];
      end
   end

   tfn_cross #(.COORD_BITS(COORD_BITS)) u_cross (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .up_coord (coord),
      .dn_valid (cr_valid),
      .dn_ready (cr_ready),
      .dn_cross (cr_n)
   );

   tfn_square #(.NW(NW), .SQW(SQW), .DWID(DWID), .FRAC(F)) u_square (
      .clock    (clock),
      .reset    (reset),
      .up_valid (cr_valid),
      .up_ready (cr_ready),
      .up_cross (cr_n),
      .dn_valid (st_valid[0]),
      .dn_ready (st_ready[0]),
      .dn_d     (st_d[0]),
      .dn_p     (st_p[0]),
      .dn_neg   (st_neg[0]),
      .dn_zero  (st_zero[0]),
      .dn_sq    (st_sq[0])
   );

   assign st_n[0] = '0;

   for (genvar i = 0; i <= F; i++) begin : g_step
      tfn_step #(.SQW(SQW), .DWID(DWID), .FRAC(F), .BIT(F - i)) u_step (
         .clock    (clock),
         .reset    (reset),
         .up_valid (st_valid[i]),
         .up_ready (st_ready[i]),
         .up_d     (st_d[i]),
         .up_p     (st_p[i]),
         .up_n     (st_n[i]),
         .up_neg   (st_neg[i]),
         .up_zero  (st_zero[i]),
         .up_sq    (st_sq[i]),
         .dn_valid (st_valid[i+1]),
         .dn_ready (st_ready[i+1]),
         .dn_d     (st_d[i+1]),
         .dn_p     (st_p[i+1]),
         .dn_n     (st_n[i+1]),
         .dn_neg   (st_neg[i+1]),
         .dn_zero  (st_zero[i+1]),
         .dn_sq    (st_sq[i+1])
      );
   end

   assign st_ready[F+1] = !out_vld_ff || rsp_tready;

   // apply sign; a degenerate triangle yields the x axis
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         norm_in[j] = st_neg[F+1][j] ? OW'(0) - OW'(st_n[F+1][j]) : OW'(st_n[F+1][j]);
      end
      if (st_zero[F+1]) begin
         norm_in[0] = OW'(1) << F;
         norm_in[1] = '0;
         norm_in[2] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (st_ready[F+1]) begin
         out_vld_ff <= st_valid[F+1];
      end
   end

   always_ff @(posedge clock) begin
      if (st_ready[F+1]) norm_ff <= norm_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = OUT_W'(norm_ff);
endmodule

// ===== rtl/tfn_checker.sv =====
`timescale 1ns / 1ps
module tfn_checker import tfn_pkg::*; #(
   parameter int NORMAL_FRAC_BITS = NORM_FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((NUM_NORM_FIELDS*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] rsp_tdata
);
   localparam int OW = NORMAL_FRAC_BITS + 2;
   localparam int LIM = 2 ** NORMAL_FRAC_BITS;

   logic signed [OW-1:0] nx, ny, nz;
   assign nx = rsp_tdata[OW-1:0];
   assign ny = rsp_tdata[2*OW-1:OW];
   assign nz = rsp_tdata[3*OW-1:2*OW];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (nx <= LIM && nx >= -LIM && ny <= LIM && ny >= -LIM
                      && nz <= LIM && nz >= -LIM))
      else $error("normal component out of range");

   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (nx != 0 || ny != 0 || nz != 0))
      else $error("normal is the zero vector");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
endmodule

bind triangle_face_normal tfn_checker #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_tfn_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== sim/tb_triangle_face_normal.sv =====
`timescale 1ns / 1ps
module tb_triangle_face_normal;
   import tfn_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int NF = NORM_FRAC_BITS_DEF;
   localparam int NW = NF + 2;
   localparam int REQ_W = ((NUM_VERTEX_FIELDS*CB+7)/8)*8;
   localparam int RSP_W = ((NUM_NORM_FIELDS*NW+7)/8)*8;
   localparam int LATENCY = 10 + NF;
   localparam int NUM_RANDOM = 1800;
   localparam longint CMAX = (64'sd1 << (CB-1)) - 1;
   localparam longint CMIN = -(64'sd1 << (CB-1));

   typedef logic [REQ_W-1:0] tri_word_t;
   typedef logic [RSP_W-1:0] norm_word_t;

   class normal_scoreboard;
      norm_word_t pending[$];

      function automatic logic [NW-1:0] scale_axis(logic signed [63:0] c, logic [255:0] sq);
         logic [255:0] mag, t, t2, k, lhs;
         int n, cand;
         mag = (c < 0) ? 256'(-c) : 256'(c);
         t = mag << (NF + 1);
         t2 = t * t;
         n = 0;
         for (int b = NF; b >= 0; b--) begin
            cand = n | (1 << b);
            if (cand <= (1 << NF)) begin
               k = 256'(2 * cand - 1);
               lhs = k * k * sq;
               if (lhs <= t2) n = cand;
            end
         end
         return (c < 0) ? NW'(-n) : NW'(n);
      endfunction

      function automatic norm_word_t face_normal(tri_word_t w);
         longint v[9];
         longint ux, uy, uz, vx, vy, vz;
         logic signed [63:0] nx, ny, nz;
         logic signed [255:0] sx, sy, sz;
         logic [255:0] sq;
         norm_word_t r;
         for (int i = 0; i < 9; i++) v[i] = longint'($signed(w[i*CB +: CB]));
         ux = v[3] - v[0]; uy = v[4] - v[1]; uz = v[5] - v[2];
         vx = v[6] - v[0]; vy = v[7] - v[1]; vz = v[8] - v[2];
         nx = uy * vz - uz * vy;
         ny = uz * vx - ux * vz;
         nz = ux * vy - uy * vx;
         sx = nx; sy = ny; sz = nz;
         sq = sx * sx + sy * sy + sz * sz;
         r = '0;
         if (sq == 0) begin
            r[0 +: NW] = NW'(1 << NF);
         end else begin
            r[0 +: NW]    = scale_axis(nx, sq);
            r[NW +: NW]   = scale_axis(ny, sq);
            r[2*NW +: NW] = scale_axis(nz, sq);
         end
         return r;
      endfunction

      function void note(tri_word_t w);
         pending.insert(pending.size(), face_normal(w));
      endfunction

      // 0: match, 1: field mismatch, 2: nothing expected
      function int check(norm_word_t got, output norm_word_t want);
         want = '0;
         if (pending.size() == 0) return 2;
         want = pending.pop_front();
         return (got === want) ? 0 : 1;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   tri_word_t req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   norm_word_t rsp_tdata;

   normal_scoreboard sb;
   int errors = 0;
   int results_seen = 0;
   bit sending_done = 1'b0;
   bit burst_mode = 1'b0;

   triangle_face_normal dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(string what, norm_word_t got, norm_word_t want);
      errors++;
      $display("mismatch %s: got x=%0d y=%0d z=%0d want x=%0d y=%0d z=%0d", what,
               $signed(got[0 +: NW]), $signed(got[NW +: NW]), $signed(got[2*NW +: NW]),
               $signed(want[0 +: NW]), $signed(want[NW +: NW]), $signed(want[2*NW +: NW]));
   endtask

   function automatic int draw_gap();
      return burst_mode ? 0 : $urandom_range(0, 17);
   endfunction

   function automatic tri_word_t pack_tri(longint v[9]);
      tri_word_t w;
      w = '0;
      for (int i = 0; i < 9; i++) w[i*CB +: CB] = CB'(v[i]);
      return w;
   endfunction

   task automatic send_tri(tri_word_t w);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      do @(posedge clock); while (!req_tready);
      sb.note(w);
      @(negedge clock);
   endtask

   task automatic send_coords(longint v[9]);
      send_tri(pack_tri(v));
   endtask

   function automatic longint rand_coord();
      return longint'($signed(CB'($urandom())));
   endfunction

   // receiver: random stalls, one long hold to back up the pipeline
   initial begin
      int gap;
      norm_word_t want;
      int verdict;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap();
         if (results_seen == 300) gap = 400;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         verdict = sb.check(rsp_tdata, want);
         if (verdict == 2) report_mismatch("unexpected result", rsp_tdata, want);
         else if (verdict == 1) report_mismatch("field", rsp_tdata, want);
         results_seen++;
         @(negedge clock);
      end
   end

   initial begin
      longint v[9];
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // degenerate: all coincident at zero
      v = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_coords(v);
      // collinear
      v = '{0, 0, 0, 65536, 65536, 65536, 131072, 131072, 131072}; send_coords(v);
      v = '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}; send_coords(v);
      // axis-aligned triangles, both windings
      v = '{0, 0, 0, 65536, 0, 0, 0, 65536, 0}; send_coords(v);
      v = '{0, 0, 0, 0, 65536, 0, 65536, 0, 0}; send_coords(v);
      v = '{0, 0, 0, 0, 65536, 0, 0, 0, 65536}; send_coords(v);
      v = '{0, 0, 0, 0, 0, 65536, 65536, 0, 0}; send_coords(v);
      // coordinate extremes
      v = '{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN}; send_coords(v);
      v = '{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX}; send_coords(v);
      v = '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX}; send_coords(v);
      v = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN}; send_coords(v);
      v = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX}; send_coords(v);
      // tiny and diagonal normals
      v = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; send_coords(v);
      v = '{0, 0, 0, 1, 0, 0, 0, 0, 1}; send_coords(v);
      v = '{0, 0, 0, 1, -1, 0, 0, 1, -1}; send_coords(v);
      v = '{-1, -1, -1, 0, 0, -1, -1, 0, 0}; send_coords(v);
      v = '{0, 0, 0, 3, 0, 0, 0, 4, 0}; send_coords(v);
      v = '{0, 0, 0, 1, 2, 2, 2, 1, -2}; send_coords(v);
      v = '{0, 0, 0, 1, 1, 0, 0, 1, 1}; send_coords(v);
      v = '{CMAX, 0, 0, CMIN, 0, 0, 0, CMAX, CMIN}; send_coords(v);

      for (int n = 0; n < NUM_RANDOM; n++) begin
         int kind;
         longint base;
         burst_mode = ((n / 150) % 4 == 1);
         if (n == 1200) begin
            req_tvalid <= 1'b0;
            while (sb.pending.size() != 0) @(negedge clock);
         end
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            for (int i = 0; i < 9; i++) v[i] = rand_coord();
         end else if (kind < 8) begin
            // small triangle around a random point
            for (int i = 0; i < 3; i++) begin
               base = rand_coord() / 2;
               v[i] = base;
               v[i+3] = base + $signed($urandom_range(0, 2000)) - 1000;
               v[i+6] = base + $signed($urandom_range(0, 2000)) - 1000;
            end
         end else if (kind == 8) begin
            // collinear or coincident
            for (int i = 0; i < 3; i++) begin
               base = rand_coord() / 4;
               v[i] = base;
               v[i+3] = base + (i + 1) * 100;
               v[i+6] = base + (i + 1) * 300;
            end
            if ($urandom_range(0, 1)) for (int i = 3; i < 9; i++) v[i] = v[i%3];
         end else begin
            for (int i = 0; i < 9; i++) v[i] = $urandom_range(0, 1) ? CMAX : CMIN;
         end
         send_coords(v);
      end
      req_tvalid <= 1'b0;
      sending_done = 1'b1;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY * 2) @(posedge clock);
      if (errors == 0 && sb.pending.size() == 0)
         $display("tb_triangle_face_normal: PASS");
      else
         $display("tb_triangle_face_normal: FAIL");
      $finish;
   end

   initial begin
      #10ms;
      $display("tb_triangle_face_normal: FAIL");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/tfn_pkg.sv
rtl/tfn_cross.sv
rtl/tfn_square.sv
rtl/tfn_step.sv
rtl/triangle_face_normal.sv
rtl/tfn_checker.sv
sim/tb_triangle_face_normal.sv
